// File: src/first_fit_block_allocator_defines.svh
// Assertion helpers used by the allocator control RTL.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

`define FBA_ASSERT_IMP(label, clk_i, rst_i, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_i) (ante) |-> (cons)) \
    else $error("allocator check failed");

`define FBA_ASSERT_NXT(label, clk_i, rst_i, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_i) (ante) |=> (cons)) \
    else $error("allocator check failed");

`else

`define FBA_ASSERT_IMP(label, clk_i, rst_i, ante, cons)

`define FBA_ASSERT_NXT(label, clk_i, rst_i, ante, cons)

`endif

`endif

// File: src/fba_pkg.sv
`timescale 1ns / 1ps

package fba_pkg;

  localparam int DESCRIPTORS = 1024;
  localparam int IDX_W       = $clog2(DESCRIPTORS);
  localparam int CNT_W       = $clog2(DESCRIPTORS + 1);
  localparam int DESC_IDX_W  = 10;
  localparam int CFG_AW      = 3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOFIT    = 2'd1;
  localparam logic [1:0] ST_NOSPARE  = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic REG_POOL_SIZE   = 1'b0;
  localparam logic REG_CANARY_SIZE = 1'b1;

  localparam logic [31:0] POOL_SIZE_RST   = 32'd504857600;
  localparam logic [7:0]  CANARY_SIZE_RST = 8'd10;

  typedef struct packed {
    logic        busy;
    logic [31:0] offset;
    logic [31:0] size;
    logic [31:0] span;
  } desc_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    desc_t            wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [31:0] pool_size;
    logic [7:0]  canary_size;
  } cfg_t;

endpackage

// File: src/first_fit_block_allocator.sv
// First-fit block allocator over a single data pool.
// Input channel (in_valid/in_ready): opcode 0 allocates in_req_size usable bytes,
// opcode 1 frees the block at pool offset in_block_addr. One request at a time.
// Result channel (out_valid/out_ready): status, pool offset and descriptor index,
// exactly one result per request, held in an output register.
// Configuration: APB-style port, pool_size at 0x0, canary_size at 0x4; write only
// while no request is in flight.
// The descriptors in use are scanned one entry per cycle through the single read
// port of the descriptor memory, then up to two write-backs follow. The first
// allocation adds a set-up step before the scan.
// in_ready rises as soon as the result is registered, even while that result
// still waits in the output register.
// Reset: all descriptors unused, pool not set up, registers to their defaults.
// No clearing pass is needed: entries in use always form a prefix tracked by a count.
// A stalled receiver holds the result; the block then waits before delivering the next.
`timescale 1ns / 1ps

module first_fit_block_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_opcode,
  input  logic [31:0]                    in_req_size,
  input  logic [31:0]                    in_block_addr,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_status,
  output logic [31:0]                    out_result_addr,
  output logic [fba_pkg::DESC_IDX_W-1:0] out_desc_index,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [fba_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);
  import fba_pkg::*;

  cfg_t     cfg;
  mem_req_t mem_req;
  desc_t    rd_data;

  fba_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  fba_desc_mem u_mem (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  fba_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_req_size     (in_req_size),
    .in_block_addr   (in_block_addr),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_result_addr (out_result_addr),
    .out_desc_index  (out_desc_index),
    .mem_req         (mem_req),
    .rd_data         (rd_data)
  );

endmodule

// File: src/fba_desc_mem.sv
`timescale 1ns / 1ps

module fba_desc_mem (
  input  logic              clk,
  input  fba_pkg::mem_req_t mem_req,
  output fba_pkg::desc_t    rd_data
);
  import fba_pkg::*;

  desc_t mem [DESCRIPTORS];
  desc_t rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
    rd_data_r <= mem[mem_req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/fba_cfg_regs.sv
`timescale 1ns / 1ps

module fba_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [fba_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready,
  output fba_pkg::cfg_t             cfg
);
  import fba_pkg::*;

  logic [31:0] pool_size_r, pool_size_nxt;
  logic [7:0]  canary_size_r, canary_size_nxt;
  logic        wr_en;
  logic        reg_sel;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  // word index only: byte lanes below bit 2 are ignored
  assign reg_sel    = cfg_paddr[2];

  always_comb begin
    pool_size_nxt   = pool_size_r;
    canary_size_nxt = canary_size_r;
    if (wr_en) begin
      case (reg_sel)
        REG_POOL_SIZE:   pool_size_nxt   = cfg_pwdata;
        REG_CANARY_SIZE: canary_size_nxt = cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_size_r   <= POOL_SIZE_RST;
      canary_size_r <= CANARY_SIZE_RST;
    end else begin
      pool_size_r   <= pool_size_nxt;
      canary_size_r <= canary_size_nxt;
    end
  end

  always_comb begin
    case (reg_sel)
      REG_POOL_SIZE:   cfg_prdata = pool_size_r;
      REG_CANARY_SIZE: cfg_prdata = {24'd0, canary_size_r};
      default:         cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.pool_size   = pool_size_r;
  assign cfg.canary_size = canary_size_r;

endmodule

// File: src/fba_ctrl.sv
`timescale 1ns / 1ps
`include "first_fit_block_allocator_defines.svh"

module fba_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fba_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic [31:0]                   in_req_size,
  input  logic [31:0]                   in_block_addr,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [31:0]                   out_result_addr,
  output logic [fba_pkg::DESC_IDX_W-1:0] out_desc_index,
  output fba_pkg::mem_req_t             mem_req,
  input  fba_pkg::desc_t                rd_data
);
  import fba_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SETUP  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_SPLIT  = 3'd3;
  localparam logic [2:0] S_FITWR  = 3'd4;
  localparam logic [2:0] S_FREEWR = 3'd5;
  localparam logic [2:0] S_RESP   = 3'd6;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DESCRIPTORS);

  logic [2:0]       state_r, state_nxt;
  logic             op_r, op_nxt;
  logic [31:0]      req_r, req_nxt;
  logic [31:0]      addr_r, addr_nxt;
  logic [32:0]      g_r, g_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic             chk_vld_r, chk_vld_nxt;
  logic [CNT_W-1:0] chk_idx_r, chk_idx_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] fit_idx_r, fit_idx_nxt;
  desc_t            fit_r, fit_nxt;
  logic [1:0]       res_status_r, res_status_nxt;
  logic [31:0]      res_addr_r, res_addr_nxt;
  logic [IDX_W-1:0] res_idx_r, res_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [31:0]      out_addr_r, out_addr_nxt;
  logic [IDX_W-1:0] out_idx_r, out_idx_nxt;

  logic             hit;
  logic             last;
  logic [31:0]      setup_size;
  logic [32:0]      rest_wide;

  assign hit  = (op_r == OP_ALLOC) ? (!rd_data.busy && (rd_data.size > req_r))
                                   : (rd_data.offset == addr_r);
  assign last = (chk_idx_r == (count_r - 1'b1));

  assign setup_size = (cfg.pool_size > {24'd0, cfg.canary_size})
                    ? (cfg.pool_size - {24'd0, cfg.canary_size}) : 32'd0;
  assign rest_wide  = {1'b0, fit_r.size} - g_r;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    req_nxt        = req_r;
    addr_nxt       = addr_r;
    g_nxt          = g_r;
    ptr_nxt        = ptr_r;
    chk_vld_nxt    = chk_vld_r;
    chk_idx_nxt    = chk_idx_r;
    count_nxt      = count_r;
    fit_idx_nxt    = fit_idx_r;
    fit_nxt        = fit_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    res_idx_nxt    = res_idx_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_idx_nxt    = out_idx_r;

    mem_req       = '0;
    mem_req.raddr = ptr_r[IDX_W-1:0];

    // drop the held result once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt      = in_opcode;
          req_nxt     = in_req_size;
          addr_nxt    = in_block_addr;
          g_nxt       = {1'b0, in_req_size} + {25'd0, cfg.canary_size};
          ptr_nxt     = '0;
          chk_vld_nxt = 1'b0;
          if (count_r == '0) begin
            if (in_opcode == OP_ALLOC) begin
              state_nxt = S_SETUP;
            end else begin
              res_status_nxt = ST_NOTFOUND;
              res_addr_nxt   = 32'd0;
              res_idx_nxt    = '0;
              state_nxt      = S_RESP;
            end
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SETUP: begin
        mem_req.we           = 1'b1;
        mem_req.waddr        = '0;
        mem_req.wdata.busy   = 1'b0;
        mem_req.wdata.offset = 32'd0;
        mem_req.wdata.size   = setup_size;
        mem_req.wdata.span   = cfg.pool_size;
        count_nxt            = CNT_W'(1);
        ptr_nxt              = '0;
        chk_vld_nxt          = 1'b0;
        state_nxt            = S_SCAN;
      end
      S_SCAN: begin
        // one read issued and one entry checked per cycle
        ptr_nxt     = ptr_r + 1'b1;
        chk_vld_nxt = 1'b1;
        chk_idx_nxt = ptr_r;
        if (chk_vld_r) begin
          if (hit) begin
            fit_idx_nxt = chk_idx_r[IDX_W-1:0];
            fit_nxt     = rd_data;
            chk_vld_nxt = 1'b0;
            if (op_r == OP_FREE) begin
              state_nxt = S_FREEWR;
            end else if (count_r == CNT_FULL) begin
              res_status_nxt = ST_NOSPARE;
              res_addr_nxt   = 32'd0;
              res_idx_nxt    = '0;
              state_nxt      = S_RESP;
            end else begin
              state_nxt = S_SPLIT;
            end
          end else if (last) begin
            chk_vld_nxt    = 1'b0;
            res_status_nxt = (op_r == OP_ALLOC) ? ST_NOFIT : ST_NOTFOUND;
            res_addr_nxt   = 32'd0;
            res_idx_nxt    = '0;
            state_nxt      = S_RESP;
          end
        end
      end
      S_SPLIT: begin
        // remainder goes into the first unused entry
        mem_req.we           = 1'b1;
        mem_req.waddr        = count_r[IDX_W-1:0];
        mem_req.wdata.busy   = 1'b0;
        mem_req.wdata.offset = fit_r.offset + g_r[31:0];
        mem_req.wdata.span   = fit_r.span - g_r[31:0];
        mem_req.wdata.size   = ({1'b0, fit_r.size} > g_r) ? rest_wide[31:0] : 32'd0;
        count_nxt            = count_r + 1'b1;
        state_nxt            = S_FITWR;
      end
      S_FITWR: begin
        mem_req.we           = 1'b1;
        mem_req.waddr        = fit_idx_r;
        mem_req.wdata.busy   = 1'b1;
        mem_req.wdata.offset = fit_r.offset;
        mem_req.wdata.size   = req_r;
        mem_req.wdata.span   = g_r[31:0];
        res_status_nxt       = ST_OK;
        res_addr_nxt         = fit_r.offset;
        res_idx_nxt          = fit_idx_r;
        state_nxt            = S_RESP;
      end
      S_FREEWR: begin
        mem_req.we         = 1'b1;
        mem_req.waddr      = fit_idx_r;
        mem_req.wdata      = fit_r;
        mem_req.wdata.busy = 1'b0;
        res_status_nxt     = ST_OK;
        res_addr_nxt       = 32'd0;
        res_idx_nxt        = fit_idx_r;
        state_nxt          = S_RESP;
      end
      S_RESP: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_addr_nxt   = res_addr_r;
          out_idx_nxt    = res_idx_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    req_r        <= req_nxt;
    addr_r       <= addr_nxt;
    g_r          <= g_nxt;
    ptr_r        <= ptr_nxt;
    chk_idx_r    <= chk_idx_nxt;
    fit_idx_r    <= fit_idx_nxt;
    fit_r        <= fit_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    res_idx_r    <= res_idx_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_idx_r    <= out_idx_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_result_addr = out_addr_r;
  assign out_desc_index  = DESC_IDX_W'(out_idx_r);

  `FBA_ASSERT_IMP(a_wr_state, clk, rst_n, mem_req.we,
    (state_r == S_SETUP) || (state_r == S_SPLIT) || (state_r == S_FITWR) ||
    (state_r == S_FREEWR))
  `FBA_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_r <= CNT_FULL)
  `FBA_ASSERT_IMP(a_split_spare, clk, rst_n, state_r == S_SPLIT,
    (count_r < CNT_FULL) && (count_r != '0))
  `FBA_ASSERT_IMP(a_chk_range, clk, rst_n, (state_r == S_SCAN) && chk_vld_r,
    chk_idx_r < count_r)
  `FBA_ASSERT_NXT(a_accept_busy, clk, rst_n, in_valid && in_ready, state_r != S_IDLE)

endmodule
